/* hdl/integer_matrix_similarity_reduce_top_macros.svh */
// assertion macros for the matrix similarity reduction block
`ifndef INTEGER_MATRIX_SIMILARITY_REDUCE_TOP_MACROS_SVH
`define INTEGER_MATRIX_SIMILARITY_REDUCE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, idle during reset
`define IMSR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define IMSR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/imsr_pkg.sv */
// shared types and constants for the matrix similarity reduction block
package imsr_pkg;

    localparam int AW    = 16;   // input entry width
    localparam int CW    = 32;   // matrix entry width
    localparam int VW    = 22;   // eigenvector and euclid width
    localparam int DW    = 34;   // divider width
    localparam int SQW   = 36;   // discriminant width
    localparam int SQ_STEPS = SQW / 2;
    localparam int MM_LAST  = 9;
    localparam int IN_W  = 4 * AW;
    localparam int OUT_W = ((8 * CW + 2 + 7) / 8) * 8;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOEIG = 2'd1;
    localparam logic [1:0] STAT_OVF   = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_TR, OP_Q1, OP_Q2, OP_DISC, OP_SQRT, OP_LAM, OP_VEC,
        OP_GSTEP, OP_NORM0, OP_NORM1, OP_EINIT, OP_EPUSH, OP_BINIT, OP_BMUL,
        OP_BUPD, OP_SMAT, OP_DET1, OP_DET2, OP_SETUP, OP_MMUL, OP_SETFL,
        OP_SETSH, OP_SETRF, OP_FAIL, OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        DS_GCD, DS_NORM0, DS_NORM1, DS_EGCD, DS_SHEAR
    } dsel_t;

    typedef enum logic [1:0] {
        MM_XI_C, MM_C_P, MM_C_X, MM_P_X
    } mm_t;

    typedef enum logic [1:0] {
        STG_INIT, STG_FLIP, STG_SHEAR, STG_REFL
    } stg_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_TR, ST_Q1, ST_Q2, ST_DISC, ST_CHK, ST_SQRT, ST_SQCHK,
        ST_LAM, ST_VEC, ST_GCD, ST_GWAIT, ST_N0, ST_N0W, ST_N1, ST_N1W,
        ST_EINIT, ST_ELOOP, ST_EWAIT, ST_BINIT, ST_BMUL, ST_BUPD, ST_SMAT,
        ST_DET1, ST_DET2, ST_SETUP, ST_MM, ST_FLCHK, ST_SHCHK, ST_SHWAIT,
        ST_RFCHK, ST_FAIL, ST_OUT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] step;
        mm_t        mm;
        logic       div_start;
        dsel_t      dsel;
    } cmd_t;

    typedef struct packed {
        logic disc_neg;
        logic rem_zero;
        logic gb_zero;
        logic g_gt1;
        logic ea_zero;
        logic n_zero;
        logic div_done;
        logic div_busy;
        logic c01_neg;
        logic shear_go;
        logic refl_go;
        logic ovf;
    } stat_t;

endpackage

/* hdl/imsr_div.sv */
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module imsr_div
    import imsr_pkg::*;
#(
    parameter int W = 34
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic                busy,
    output logic                done,
    output logic signed [W-1:0] quot,
    output logic signed [W-1:0] rem
);

    localparam int CNTW = $clog2(W + 1);

    logic            busy_reg, done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0]    quo_reg, rem_reg, dmag_reg;
    logic            qneg_reg, rneg_reg;
    logic [W:0]      shifted;
    logic            fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        fits    = shifted >= {1'b0, dmag_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= num[W-1] ? (~num + 1'b1) : num;
            dmag_reg <= den[W-1] ? (~den + 1'b1) : den;
            rem_reg  <= '0;
            qneg_reg <= num[W-1] ^ den[W-1];
            rneg_reg <= num[W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? W'(shifted - {1'b0, dmag_reg}) : shifted[W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = qneg_reg ? $signed(~quo_reg + 1'b1) : $signed(quo_reg);
    assign rem  = rneg_reg ? $signed(~rem_reg + 1'b1) : $signed(rem_reg);

endmodule

/* hdl/imsr_dp.sv */
// datapath: shared multiplier, divider, euclid stack and matrix registers
module imsr_dp
    import imsr_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [IN_W-1:0]  a_in,
    output stat_t            st,
    output logic [OUT_W-1:0] out_data
);

    localparam int NW = $clog2(STACK_DEPTH) + 1;
    localparam logic signed [DW-1:0] K_HI = DW'(64'sd2147483647);

    logic signed [AW-1:0]  a_reg [4];
    logic signed [17:0]    tr_reg;
    logic signed [33:0]    qp_reg, q_reg;
    logic signed [SQW-1:0] disc_reg;
    logic [SQW-1:0]        rem_reg, res_reg;
    logic signed [19:0]    lam_reg;
    logic                  distinct_reg;
    logic signed [VW-1:0]  v0_reg, v1_reg, ea_reg, eb_reg;
    logic [VW-1:0]         ga_reg, gb_reg;
    logic signed [VW-1:0]  qstk_reg [STACK_DEPTH];
    logic [NW-1:0]         n_reg;
    logic signed [CW-1:0]  cx_reg, cy_reg;
    logic signed [CW-1:0]  c_reg [4];
    logic signed [CW-1:0]  p_reg [4];
    logic signed [CW-1:0]  x_reg [4];
    logic signed [CW-1:0]  xi_reg [4];
    logic signed [CW-1:0]  t_reg [4];
    logic signed [63:0]    prod_reg, macc_reg;
    logic                  ovf_reg, fail_reg;
    logic [OUT_W-1:0]      out_reg;

    logic signed [CW-1:0]  mul_a, mul_b;
    logic [5:0]            sq_sh;
    logic [SQW-1:0]        sq_bit, sq_trial;
    logic signed [19:0]    ld, lam_n;
    logic signed [VW-1:0]  m0, m3, nv0, nv1;
    logic [1:0]            lidx, ridx;
    logic [2:0]            ms, pr;
    logic signed [CW-1:0]  lop, rop;
    logic signed [64:0]    msum;
    logic                  mfit;
    logic signed [32:0]    w, w2;
    logic signed [DW-1:0]  dnum, dden, dquot, drem, kq;
    logic                  dbusy, ddone, kbad, detneg;
    logic [NW-2:0]         top_idx;
    logic [1:0]            stat;

    imsr_div #(.W(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (dnum),
        .den   (dden),
        .busy  (dbusy),
        .done  (ddone),
        .quot  (dquot),
        .rem   (drem)
    );

    always_comb
    begin
        top_idx  = n_reg[NW-2:0] - 1'b1;
        sq_sh    = 6'(SQW - 2) - {cmd.step, 1'b0};
        sq_bit   = SQW'(1) << sq_sh;
        sq_trial = res_reg + sq_bit;
        ld       = 20'(tr_reg) - 20'($signed({1'b0, res_reg[17:0]}));
        lam_n    = (ld + $signed({19'b0, ld[19]})) >>> 1;
        m0       = VW'(a_reg[0]) - VW'(lam_reg);
        m3       = VW'(a_reg[3]) - VW'(lam_reg);
        if (m0 != 0 || a_reg[1] != 0)
        begin
            nv0 = m0;
            nv1 = VW'(a_reg[1]);
        end
        else if (a_reg[2] != 0 || m3 != 0)
        begin
            nv0 = VW'(a_reg[2]);
            nv1 = m3;
        end
        else
        begin
            nv0 = '0;
            nv1 = VW'(1);
        end

        // matrix product walk: element in step[2:1], inner term in step[0]
        ms   = cmd.step[2:0];
        pr   = ms - 1'b1;
        lidx = {ms[2], ms[0]};
        ridx = {ms[0], ms[1]};
        case (cmd.mm)
            MM_XI_C: begin lop = xi_reg[lidx]; rop = c_reg[ridx]; end
            MM_C_P:  begin lop = c_reg[lidx];  rop = p_reg[ridx]; end
            MM_C_X:  begin lop = c_reg[lidx];  rop = x_reg[ridx]; end
            default: begin lop = p_reg[lidx];  rop = x_reg[ridx]; end
        endcase
        msum = 65'(macc_reg) + 65'(prod_reg);
        mfit = (msum[64:31] == '0) || (msum[64:31] == '1);

        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_TR:   begin mul_a = CW'(a_reg[0]); mul_b = CW'(a_reg[3]); end
            OP_Q1:   begin mul_a = CW'(a_reg[1]); mul_b = CW'(a_reg[2]); end
            OP_Q2:   begin mul_a = CW'(tr_reg);   mul_b = CW'(tr_reg);   end
            OP_BMUL: begin mul_a = CW'(qstk_reg[top_idx]); mul_b = cx_reg; end
            OP_DET1: begin mul_a = p_reg[0]; mul_b = p_reg[3]; end
            OP_DET2: begin mul_a = p_reg[1]; mul_b = p_reg[2]; end
            OP_MMUL: begin mul_a = lop; mul_b = rop; end
            default: ;
        endcase

        w      = 33'(c_reg[3]) - 33'(c_reg[0]);
        w2     = (w + $signed({32'b0, w[32]})) >>> 1;
        kq     = (w == 0) ? '0 : dquot;
        kbad   = (kq > K_HI) || (kq < -K_HI);
        detneg = (macc_reg - prod_reg) < 0;

        case (cmd.dsel)
            DS_GCD:   begin dnum = DW'($signed({1'b0, ga_reg})); dden = DW'($signed({1'b0, gb_reg})); end
            DS_NORM0: begin dnum = DW'(v0_reg); dden = DW'($signed({1'b0, ga_reg})); end
            DS_NORM1: begin dnum = DW'(v1_reg); dden = DW'($signed({1'b0, ga_reg})); end
            DS_EGCD:  begin dnum = DW'(eb_reg); dden = DW'(ea_reg); end
            default:  begin dnum = DW'(c_reg[1]); dden = DW'(w); end
        endcase

        stat = fail_reg ? STAT_NOEIG : (ovf_reg ? STAT_OVF : STAT_OK);
    end

    // control flags and stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg  <= 1'b0;
            fail_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    ovf_reg  <= 1'b0;
                    fail_reg <= 1'b0;
                end
                OP_FAIL:  fail_reg <= 1'b1;
                OP_EINIT: n_reg <= '0;
                OP_EPUSH: n_reg <= n_reg + 1'b1;
                OP_BUPD:  n_reg <= n_reg - 1'b1;
                OP_MMUL:
                    if ((ms != 3'd0 || cmd.step[3]) && cmd.step != 5'(MM_LAST) && pr[0]
                        && !mfit)
                        ovf_reg <= 1'b1;
                OP_SETSH: if (kbad) ovf_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD:
                for (int i = 0; i < 4; i++)
                    a_reg[i] <= $signed(a_in[i*AW +: AW]);
            OP_TR:   tr_reg <= 18'(a_reg[0]) + 18'(a_reg[3]);
            OP_Q1:   qp_reg <= 34'(prod_reg);
            OP_Q2:   q_reg  <= qp_reg - 34'(prod_reg);
            OP_DISC:
            begin
                disc_reg <= SQW'(prod_reg) - (SQW'(q_reg) <<< 2);
                rem_reg  <= SQW'(prod_reg) - (SQW'(q_reg) <<< 2);
                res_reg  <= '0;
            end
            OP_SQRT:
                if (rem_reg >= sq_trial)
                begin
                    rem_reg <= rem_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + sq_bit;
                end
                else
                    res_reg <= res_reg >> 1;
            OP_LAM:
            begin
                lam_reg      <= lam_n;
                distinct_reg <= res_reg != 0;
            end
            OP_VEC:
            begin
                v0_reg <= nv0;
                v1_reg <= nv1;
                ga_reg <= nv0[VW-1] ? VW'(-nv0) : VW'(nv0);
                gb_reg <= nv1[VW-1] ? VW'(-nv1) : VW'(nv1);
            end
            OP_GSTEP:
            begin
                ga_reg <= gb_reg;
                gb_reg <= drem[VW-1:0];
            end
            OP_NORM0: v0_reg <= dquot[VW-1:0];
            OP_NORM1: v1_reg <= dquot[VW-1:0];
            OP_EINIT:
            begin
                ea_reg <= v1_reg;
                eb_reg <= -v0_reg;
            end
            OP_EPUSH:
            begin
                qstk_reg[n_reg[NW-2:0]] <= dquot[VW-1:0];
                eb_reg <= ea_reg;
                ea_reg <= drem[VW-1:0];
            end
            OP_BINIT:
            begin
                cx_reg <= '0;
                cy_reg <= CW'(1);
            end
            OP_BUPD:
            begin
                cx_reg <= cy_reg - prod_reg[CW-1:0];
                cy_reg <= cx_reg;
            end
            OP_SMAT:
            begin
                p_reg[0] <= CW'(v1_reg);
                p_reg[1] <= -cy_reg;
                p_reg[2] <= -CW'(v0_reg);
                p_reg[3] <= cx_reg;
            end
            OP_DET2: macc_reg <= prod_reg;
            OP_SETUP:
            begin
                // det is +1 or -1, so the inverse is the adjugate times det
                xi_reg[0] <= detneg ? -p_reg[3] : p_reg[3];
                xi_reg[1] <= detneg ? p_reg[1] : -p_reg[1];
                xi_reg[2] <= detneg ? p_reg[2] : -p_reg[2];
                xi_reg[3] <= detneg ? -p_reg[0] : p_reg[0];
                for (int i = 0; i < 4; i++)
                    c_reg[i] <= CW'(a_reg[i]);
            end
            OP_MMUL:
            begin
                if (cmd.step == 5'(MM_LAST))
                begin
                    if (cmd.mm == MM_P_X)
                        p_reg <= t_reg;
                    else
                        c_reg <= t_reg;
                end
                else if (ms != 3'd0 || cmd.step[3])
                begin
                    if (!pr[0])
                        macc_reg <= prod_reg;
                    else
                        t_reg[pr[2:1]] <= msum[CW-1:0];
                end
            end
            OP_SETFL:
            begin
                x_reg  <= '{-CW'(1), '0, '0, CW'(1)};
                xi_reg <= '{-CW'(1), '0, '0, CW'(1)};
            end
            OP_SETSH:
            begin
                x_reg  <= '{CW'(1), kq[CW-1:0], '0, CW'(1)};
                xi_reg <= '{CW'(1), -kq[CW-1:0], '0, CW'(1)};
            end
            OP_SETRF:
            begin
                x_reg  <= '{CW'(1), -CW'(1), '0, -CW'(1)};
                xi_reg <= '{CW'(1), -CW'(1), '0, -CW'(1)};
            end
            OP_OUT:
                if (stat == STAT_OK)
                    out_reg <= {(OUT_W - 8*CW - 2)'(0), stat,
                                p_reg[3], p_reg[2], p_reg[1], p_reg[0],
                                c_reg[3], c_reg[2], c_reg[1], c_reg[0]};
                else
                    out_reg <= {(OUT_W - 8*CW - 2)'(0), stat, (8*CW)'(0)};
            default: ;
        endcase
    end

    always_comb
    begin
        st.disc_neg = disc_reg[SQW-1];
        st.rem_zero = rem_reg == 0;
        st.gb_zero  = gb_reg == 0;
        st.g_gt1    = ga_reg > VW'(1);
        st.ea_zero  = ea_reg == 0;
        st.n_zero   = n_reg == 0;
        st.div_done = ddone;
        st.div_busy = dbusy;
        st.c01_neg  = c_reg[1] < 0;
        st.shear_go = distinct_reg && (33'(c_reg[1]) >= w);
        st.refl_go  = distinct_reg && (33'(c_reg[1]) > w2);
        st.ovf      = ovf_reg;
    end

    assign out_data = out_reg;

endmodule

/* hdl/imsr_ctrl.sv */
// controller: sequences the datapath through one reduction at a time
module imsr_ctrl
    import imsr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] mmcnt_reg, mmcnt_next;
    stg_t       stage_reg, stage_next;
    logic       out_valid_reg, out_valid_next;
    mm_t        mm_cur;
    logic       mm_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            mmcnt_reg     <= '0;
            stage_reg     <= STG_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            mmcnt_reg     <= mmcnt_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (stage_reg == STG_INIT)
        begin
            mm_cur  = (mmcnt_reg == 2'd0) ? MM_XI_C : MM_C_P;
            mm_last = mmcnt_reg == 2'd1;
        end
        else
        begin
            mm_cur  = (mmcnt_reg == 2'd0) ? MM_XI_C :
                      ((mmcnt_reg == 2'd1) ? MM_C_X : MM_P_X);
            mm_last = mmcnt_reg == 2'd2;
        end

        state_next     = state_reg;
        step_next      = step_reg;
        mmcnt_next     = mmcnt_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cmd.op         = OP_NOP;
        cmd.step       = step_reg;
        cmd.mm         = mm_cur;
        cmd.div_start  = 1'b0;
        cmd.dsel       = DS_GCD;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_TR;
                end
            end
            ST_TR:   begin cmd.op = OP_TR;   state_next = ST_Q1;   end
            ST_Q1:   begin cmd.op = OP_Q1;   state_next = ST_Q2;   end
            ST_Q2:   begin cmd.op = OP_Q2;   state_next = ST_DISC; end
            ST_DISC: begin cmd.op = OP_DISC; state_next = ST_CHK;  end
            ST_CHK:
            begin
                step_next  = '0;
                state_next = st.disc_neg ? ST_FAIL : ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op    = OP_SQRT;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'(SQ_STEPS - 1))
                    state_next = ST_SQCHK;
            end
            ST_SQCHK: state_next = st.rem_zero ? ST_LAM : ST_FAIL;
            ST_LAM:   begin cmd.op = OP_LAM; state_next = ST_VEC; end
            ST_VEC:   begin cmd.op = OP_VEC; state_next = ST_GCD; end
            ST_GCD:
                if (st.gb_zero)
                    state_next = st.g_gt1 ? ST_N0 : ST_EINIT;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.dsel      = DS_GCD;
                    state_next    = ST_GWAIT;
                end
            ST_GWAIT:
                if (st.div_done)
                begin
                    cmd.op     = OP_GSTEP;
                    state_next = ST_GCD;
                end
            ST_N0:
            begin
                cmd.div_start = 1'b1;
                cmd.dsel      = DS_NORM0;
                state_next    = ST_N0W;
            end
            ST_N0W:
                if (st.div_done)
                begin
                    cmd.op     = OP_NORM0;
                    state_next = ST_N1;
                end
            ST_N1:
            begin
                cmd.div_start = 1'b1;
                cmd.dsel      = DS_NORM1;
                state_next    = ST_N1W;
            end
            ST_N1W:
                if (st.div_done)
                begin
                    cmd.op     = OP_NORM1;
                    state_next = ST_EINIT;
                end
            ST_EINIT: begin cmd.op = OP_EINIT; state_next = ST_ELOOP; end
            ST_ELOOP:
                if (st.ea_zero)
                    state_next = ST_BINIT;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.dsel      = DS_EGCD;
                    state_next    = ST_EWAIT;
                end
            ST_EWAIT:
                if (st.div_done)
                begin
                    cmd.op     = OP_EPUSH;
                    state_next = ST_ELOOP;
                end
            ST_BINIT: begin cmd.op = OP_BINIT; state_next = ST_BMUL; end
            ST_BMUL:
                if (st.n_zero)
                    state_next = ST_SMAT;
                else
                begin
                    cmd.op     = OP_BMUL;
                    state_next = ST_BUPD;
                end
            ST_BUPD:  begin cmd.op = OP_BUPD; state_next = ST_BMUL; end
            ST_SMAT:  begin cmd.op = OP_SMAT; state_next = ST_DET1; end
            ST_DET1:  begin cmd.op = OP_DET1; state_next = ST_DET2; end
            ST_DET2:  begin cmd.op = OP_DET2; state_next = ST_SETUP; end
            ST_SETUP:
            begin
                cmd.op     = OP_SETUP;
                stage_next = STG_INIT;
                mmcnt_next = '0;
                step_next  = '0;
                state_next = ST_MM;
            end
            ST_MM:
            begin
                cmd.op = OP_MMUL;
                if (step_reg == 5'(MM_LAST))
                begin
                    step_next  = '0;
                    mmcnt_next = mm_last ? 2'd0 : mmcnt_reg + 1'b1;
                    if (st.ovf)
                        state_next = ST_OUT;
                    else if (mm_last)
                    begin
                        case (stage_reg)
                            STG_INIT:  state_next = ST_FLCHK;
                            STG_FLIP:  state_next = ST_SHCHK;
                            STG_SHEAR: state_next = ST_RFCHK;
                            default:   state_next = ST_OUT;
                        endcase
                    end
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_FLCHK:
                if (st.c01_neg)
                begin
                    cmd.op     = OP_SETFL;
                    stage_next = STG_FLIP;
                    state_next = ST_MM;
                end
                else
                    state_next = ST_SHCHK;
            ST_SHCHK:
                if (st.shear_go)
                begin
                    cmd.div_start = 1'b1;
                    cmd.dsel      = DS_SHEAR;
                    state_next    = ST_SHWAIT;
                end
                else
                    state_next = ST_RFCHK;
            ST_SHWAIT:
            begin
                cmd.dsel = DS_SHEAR;
                if (st.div_done)
                begin
                    cmd.op     = OP_SETSH;
                    stage_next = STG_SHEAR;
                    state_next = ST_MM;
                end
            end
            ST_RFCHK:
                if (st.refl_go)
                begin
                    cmd.op     = OP_SETRF;
                    stage_next = STG_REFL;
                    state_next = ST_MM;
                end
                else
                    state_next = ST_OUT;
            ST_FAIL:  begin cmd.op = OP_FAIL; state_next = ST_OUT; end
            ST_OUT:
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* hdl/integer_matrix_similarity_reduce_top.sv */
// top level of the 2x2 integer matrix similarity reduction block
//
// one input transaction on the slave stream carries a 2x2 matrix a; one output
// transaction on the master stream carries the normal form c, the transform p
// with c = p^-1 a p, and a status (0 ok, 1 no integer eigenvalues, 2 overflow).
// on a non-zero status all matrix fields are zero.
// the block works on one matrix at a time: s_tready is high only while idle.
// the run time is set by the eigenvalue stage (an 18-step square root), by
// the divisions on the shared serial divider (one per gcd step, two for
// normalising, one per extended euclid step, one for the shear), by the
// back-substitution steps and by the 2x2 products on the shared 32x32
// multiplier (up to eleven products).
// the result sits in an output register; a stalled receiver holds it there
// while the next matrix is accepted and worked on, and that matrix waits only
// at its own hand-over.
// reset clears the controller and drops m_tvalid; no memory needs clearing.
`include "integer_matrix_similarity_reduce_top_macros.svh"

module integer_matrix_similarity_reduce_top
    import imsr_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // a00, a01, a10, a11
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // c00, c01, c10, c11, p00, p01, p10, p11, status
);

    cmd_t  cmd;
    stat_t st;

    imsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    imsr_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .a_in     (s_tdata),
        .st       (st),
        .out_data (m_tdata)
    );

    `IMSR_ASSERT_NOW(a_fail_zero, m_tvalid && m_tdata[8*CW +: 2] != STAT_OK, m_tdata[8*CW-1:0] == '0, "failed result carries non-zero matrix")
    `IMSR_ASSERT_NOW(a_stat_code, m_tvalid, m_tdata[8*CW +: 2] == STAT_OK || m_tdata[8*CW +: 2] == STAT_NOEIG || m_tdata[8*CW +: 2] == STAT_OVF, "unknown status code")
    `IMSR_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `IMSR_ASSERT_NOW(a_div_free, cmd.div_start, !st.div_busy, "divider restarted while busy")

endmodule
